FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Each macro expands to one labelled concurrent assertion, clocked on the
// given clock and switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define WST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The antecedent implies the consequent in the following cycle.
`define WST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/wst_pkg.sv
// ----------------------------------------------------------------------------
// wst_pkg
// Types, field layouts and helpers shared by the weekly schedule table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wst_pkg;

  localparam int unsigned ENTRY_W = 20;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 24;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Input request, last member in the lowest bits.
  typedef struct packed {
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
    logic [5:0] entry_second;
    logic [5:0] entry_minute;
    logic [4:0] entry_hour;
    logic [2:0] entry_weekday;
    logic [5:0] position;
    logic [1:0] action;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pad;
    logic [5:0] passed_count;
    logic [4:0] next_position;
    logic [5:0] entry_count;
    logic       status;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_IDX     = 2'd0,
    RD_IDX_DEC = 2'd1,
    RD_IDX_INC = 2'd2
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    clear;
    logic    set_err;
    logic    ins_setup;
    logic    del_setup;
    logic    idx_dec;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_shift;
    logic    wr_item;
    logic    cnt_dec;
    logic    scan_init;
    logic    scan_hit;
    logic    scan_miss;
    logic    publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    err;
    logic    idx_gt_pos;
    logic    pos_in_range;
    logic    del_more;
    logic    cnt_zero;
    logic    entry_ge_now;
    logic    scan_last;
  } sts_t;

  // Weekday, hour, minute and second packed so that an unsigned compare of
  // the words orders the times within a week.
  function automatic logic [ENTRY_W-1:0] pack_time(input logic [2:0] wd,
                                                   input logic [4:0] hr,
                                                   input logic [5:0] mi,
                                                   input logic [5:0] se);
    return {wd, hr, mi, se};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/weekly_schedule_table.sv
// ----------------------------------------------------------------------------
// weekly_schedule_table
// Ordered table of weekly time entries with insert, delete and clear, and a
// search for the next entry due after every insert and delete.
//
//   Channel   Dir  Fields (tdata, lowest bit first)
//   s_axis    in   action, position, entry weekday/hour/minute/second,
//                  now weekday/hour/minute/second
//   m_axis    out  status, entry_count, next_position, passed_count
//
// One request at a time; each entry moved or scanned takes a read step and then
// a write or compare step. An insert or a delete shifts the entries it moves,
// then scans for the next entry due; clear, the unused code and refused
// requests go straight to the result. A new request is taken while a result
// still waits, and its own result is held until that one is taken. Reset clears
// the count, scan and error state, but not the entry memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module weekly_schedule_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // action, position, entry_weekday, entry_hour, entry_minute, entry_second,
  // now_weekday, now_hour, now_minute, now_second
  input  wire logic [wst_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // status, entry_count, next_position, passed_count, zero padding
  output logic      [wst_pkg::OUT_W-1:0] m_axis_tdata
);

  wst_pkg::cmd_t cmd;
  wst_pkg::sts_t sts;

  wst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/wst_datapath.sv
// ----------------------------------------------------------------------------
// wst_datapath
// Entry memory, count and scan registers, and the compares the controller
// steers by.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wst_datapath #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire wst_pkg::cmd_t              cmd_i,
  output wst_pkg::sts_t                   sts_o,
  input  wire logic [wst_pkg::IN_W-1:0]   in_data_i,
  output logic      [wst_pkg::OUT_W-1:0]  out_data_o
);

  localparam int unsigned IW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > wst_pkg::POS_W) ? CW : wst_pkg::POS_W;
  localparam int unsigned NW   = (IW > 5) ? IW : 5;

  wst_pkg::in_item_t           in_item;
  wst_pkg::out_item_t          out_item;

  wst_pkg::action_e            act_q;
  logic [wst_pkg::POS_W-1:0]   pos_q;
  logic [wst_pkg::ENTRY_W-1:0] item_q;
  logic [wst_pkg::ENTRY_W-1:0] now_q;
  logic [wst_pkg::ENTRY_W-1:0] rd_q;
  logic [wst_pkg::OUT_W-1:0]   out_q;
  logic [CW-1:0]               cnt_q;
  logic [CW-1:0]               pas_q;
  logic [IW-1:0]               nxt_q;
  logic [IW-1:0]               idx_q;
  logic                        err_q;
  logic [wst_pkg::ENTRY_W-1:0] mem_q [TABLE_DEPTH];

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pas_ext;
  logic [NW-1:0]   nxt_ext;
  logic [CW-1:0]   idx_p1;
  logic [CW-1:0]   new_cnt_m1;
  logic            cnt_full;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   pos_addr;

  assign in_item  = wst_pkg::in_item_t'(in_data_i);
  assign pos_ext  = CMPW'(pos_q);
  assign cnt_ext  = CMPW'(cnt_q);
  assign pas_ext  = CMPW'(pas_q);
  assign nxt_ext  = NW'(nxt_q);
  assign idx_p1   = CW'(idx_q) + CW'(1);
  assign cnt_full = (cnt_q == CW'(TABLE_DEPTH));
  assign pos_addr = pos_ext[IW-1:0];

  // On a full table the count stays, so the top slot is the old last one.
  assign new_cnt_m1 = cnt_full ? (cnt_q - CW'(1)) : cnt_q;

  always_comb begin
    sts_o.action       = act_q;
    sts_o.err          = ((act_q == wst_pkg::ACT_INSERT) && (cnt_q != '0) &&
                          (pos_ext > cnt_ext)) ||
                         ((act_q == wst_pkg::ACT_DELETE) && (pos_ext >= cnt_ext));
    sts_o.idx_gt_pos   = (CMPW'(idx_q) > pos_ext);
    sts_o.pos_in_range = (pos_ext < CMPW'(TABLE_DEPTH));
    sts_o.del_more     = (idx_p1 < cnt_q);
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.entry_ge_now = (rd_q >= now_q);
    sts_o.scan_last    = (idx_p1 >= cnt_q);
  end

  always_comb begin
    case (cmd_i.rd_sel)
      wst_pkg::RD_IDX_DEC: rd_addr = idx_q - IW'(1);
      wst_pkg::RD_IDX_INC: rd_addr = idx_q + IW'(1);
      default:             rd_addr = idx_q;
    endcase
  end

  // Entry memory: one read and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.wr_shift) begin
      mem_q[idx_q] <= rd_q;
    end else if (cmd_i.wr_item) begin
      mem_q[pos_addr] <= item_q;
    end
  end

  // Request operands, held for the whole operation save the position noted below.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= wst_pkg::action_e'(in_item.action);
      pos_q  <= in_item.position;
      item_q <= wst_pkg::pack_time(in_item.entry_weekday, in_item.entry_hour,
                                   in_item.entry_minute, in_item.entry_second);
      now_q  <= wst_pkg::pack_time(in_item.now_weekday, in_item.now_hour,
                                   in_item.now_minute, in_item.now_second);
    end else if (cmd_i.ins_setup && (cnt_q == '0)) begin
      // An insert into an empty table always lands in slot 0.
      pos_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_setup) begin
      idx_q <= new_cnt_m1[IW-1:0];
    end else if (cmd_i.del_setup) begin
      idx_q <= pos_addr;
    end else if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - IW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      nxt_q <= '0;
      pas_q <= '0;
      err_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        err_q <= 1'b0;
      end else if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end

      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.ins_setup) begin
        cnt_q <= new_cnt_m1 + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end

      if (cmd_i.clear || cmd_i.scan_init) begin
        nxt_q <= '0;
        pas_q <= '0;
      end else if (cmd_i.scan_hit) begin
        nxt_q <= idx_q;
        pas_q <= CW'(idx_q);
      end else if (cmd_i.scan_miss) begin
        // Every entry lies in the past: wrap to the first one.
        nxt_q <= '0;
        pas_q <= cnt_q;
      end
    end
  end

  always_comb begin
    out_item.pad           = '0;
    out_item.passed_count  = pas_ext[5:0];
    out_item.next_position = nxt_ext[4:0];
    out_item.entry_count   = cnt_ext[5:0];
    out_item.status        = err_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q <= out_item;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wst_ctrl.sv
// ----------------------------------------------------------------------------
// wst_ctrl
// Sequencer for the schedule table: decodes a request, steps the shifts
// and the scan one entry at a time, and hands the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic          m_tready_i,
  output logic               m_tvalid_o,
  input  wire wst_pkg::sts_t sts_i,
  output wst_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CHK,
    S_INS_MOVE,
    S_INS_PUT,
    S_DEL_CHK,
    S_DEL_MOVE,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_tready_i;
    cmd_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.err) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_DONE;
        end else begin
          unique case (sts_i.action)
            wst_pkg::ACT_INSERT: begin
              cmd_o.ins_setup = 1'b1;
              state_d         = S_INS_CHK;
            end
            wst_pkg::ACT_DELETE: begin
              cmd_o.del_setup = 1'b1;
              state_d         = S_DEL_CHK;
            end
            wst_pkg::ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = S_DONE;
            end
            wst_pkg::ACT_NOP: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      // Insert: move entries up one slot, top first, down to the position.
      S_INS_CHK: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = wst_pkg::RD_IDX_DEC;
          state_d      = S_INS_MOVE;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_MOVE: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = S_INS_CHK;
      end
      S_INS_PUT: begin
        // At the very end of a full table the new entry itself falls off.
        cmd_o.wr_item = sts_i.pos_in_range;
        state_d       = S_SCAN_INIT;
      end
      // Delete: pull later entries down one slot, lowest first.
      S_DEL_CHK: begin
        if (sts_i.del_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = wst_pkg::RD_IDX_INC;
          state_d      = S_DEL_MOVE;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_SCAN_INIT;
        end
      end
      S_DEL_MOVE: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_DEL_CHK;
      end
      S_SCAN_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = sts_i.cnt_zero ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = wst_pkg::RD_IDX;
        state_d      = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.entry_ge_now) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.scan_last) begin
          cmd_o.scan_miss = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_DONE: begin
        // Wait here only while an earlier result is still not taken.
        if (!out_valid_q || m_tready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wst_checker.sv
// ----------------------------------------------------------------------------
// wst_checker
// Port-level checks on the schedule table, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wst_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [wst_pkg::OUT_W-1:0] m_axis_tdata
);

  logic       in_take;
  logic       out_take;
  logic [1:0] outstanding_q;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // Requests taken whose results have not yet been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_take && !out_take) begin
      outstanding_q <= outstanding_q + 2'd1;
    end else if (out_take && !in_take) begin
      outstanding_q <= outstanding_q - 2'd1;
    end
  end

  `WST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `WST_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_take, !s_axis_tready)
  `WST_ASSERT_IMP(a_no_stray_result, clk_i, rst_ni, m_axis_tvalid, outstanding_q != 2'd0)
  `WST_ASSERT_IMP(a_passed_bound, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[17:12] <= m_axis_tdata[6:1])

endmodule

bind weekly_schedule_table wst_checker u_wst_checker (.*);

`default_nettype wire
